/* design/lfu_cache_with_frequency_aging_assert.svh */
// Assertion macros for the LFU cache
`ifndef LFU_CACHE_WITH_FREQUENCY_AGING_ASSERT_SVH
`define LFU_CACHE_WITH_FREQUENCY_AGING_ASSERT_SVH

// Check a property on every clock edge outside reset
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lfu_pkg.sv */
package lfu_pkg;
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_DATA_BITS = 32;
    localparam int CAP_BITS      = 5;
    localparam int THR_BITS      = 8;
    localparam int CNT_BITS      = 16;
    localparam int STAMP_BITS    = 32;
    localparam int TOTAL_BITS    = 32;
    localparam int VAL_BITS      = 32;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
    localparam logic [THR_BITS-1:0] THR_RESET = 8'd10;

    // Configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    // Commands
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;
endpackage

/* design/lfu_if.sv */
interface lfu_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] lookup_key;
    logic [31:0] put_value;
    modport source (output valid, cmd, lookup_key, put_value, input ready);
    modport sink (input valid, cmd, lookup_key, put_value, output ready);
endinterface

interface lfu_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] read_value;
    modport source (output valid, hit, read_value, input ready);
    modport sink (input valid, hit, read_value, output ready);
endinterface

interface lfu_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [7:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/lfu_cache_with_frequency_aging.sv */
// LFU cache with aging: per access one scan over all slots, then optional aging pass.
// A get miss or a put at capacity zero answers after the scan; a hit or an insert writes the slot,
// then runs a 32-bit restoring divide of the access total by occupancy, and an aging pass
// follows when the quotient exceeds the threshold.
// Throughput: one access at a time; the next request is taken in the cycle after the result beat.
// Reset: all slots invalid, counters zero, capacity 16, threshold 10; no clearing pass.
module lfu_cache_with_frequency_aging #(
    parameter int ENTRIES   = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = lfu_pkg::DEF_KEY_BITS,
    parameter int DATA_BITS = lfu_pkg::DEF_DATA_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    lfu_req_if.sink  req,
    lfu_rsp_if.source rsp,
    lfu_cfg_if.sink  cfg
);
    import lfu_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int DW = TOTAL_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam logic [OW-1:0] ENT_O = OW'(ENTRIES);

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [DATA_BITS-1:0]  data;
        logic [CNT_BITS-1:0]   cnt;
        logic [STAMP_BITS-1:0] stamp;
    } slot_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SCAN   = 11'b00000000010,
        S_DEC    = 11'b00000000100,
        S_EVRD   = 11'b00000001000,
        S_EVWT   = 11'b00000010000,
        S_WRITE  = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_AGERD  = 11'b00010000000,
        S_AGEWT  = 11'b00100000000,
        S_AGEWR  = 11'b01000000000,
        S_RESP   = 11'b10000000000
    } state_t;

    // Slot memory and valid bits
    slot_t mem [ENTRIES];
    slot_t rd_data;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    slot_t         wr_data;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CAP_BITS-1:0] cap_reg, cap_next;
    logic [THR_BITS-1:0] thr_reg, thr_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [DATA_BITS-1:0] val_reg, val_next;
    // Scan: issue counter and check counter (check trails issue by the registered read)
    logic [OW-1:0] iss_reg, iss_next;
    logic [OW-1:0] chk_reg, chk_next;
    logic hit_reg, hit_next;
    logic [IW-1:0] hidx_reg, hidx_next;
    slot_t hslot_reg, hslot_next;
    logic vfound_reg, vfound_next;
    logic [IW-1:0] vidx_reg, vidx_next;
    logic [CNT_BITS-1:0] vcnt_reg, vcnt_next;
    logic [STAMP_BITS-1:0] vage_reg, vage_next;
    logic ffound_reg, ffound_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic rv_reg, rv_next;
    logic [31:0] rdval_reg, rdval_next;
    logic out_valid_reg, out_valid_next;
    // Divider
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;

    logic [DW:0] rem_shift;
    logic [CNT_BITS-1:0] dec;
    logic [STAMP_BITS-1:0] cur_age;
    logic [IW-1:0] chk_idx;
    logic [CAP_BITS-1:0] cap_eff;

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.hit = rv_reg;
    assign rsp.read_value = rdval_reg;

    assign dec = CNT_BITS'(thr_reg >> 1);
    assign cur_age = stamp_reg - rd_data.stamp;
    assign chk_idx = chk_reg[IW-1:0];
    assign rem_shift = {rem_reg[DW-1:0], quo_reg[DW-1]};
    assign cap_eff = (CAP_BITS'(ENTRIES) < cap_reg && ENTRIES < 32)
        ? CAP_BITS'(ENTRIES) : cap_reg;

    always_comb
    begin
        state_next = state_reg;
        cap_next = cap_reg;
        thr_next = thr_reg;
        stamp_next = stamp_reg;
        total_next = total_reg;
        occ_next = occ_reg;
        cmd_next = cmd_reg;
        key_next = key_reg;
        val_next = val_reg;
        iss_next = iss_reg;
        chk_next = chk_reg;
        hit_next = hit_reg;
        hidx_next = hidx_reg;
        hslot_next = hslot_reg;
        vfound_next = vfound_reg;
        vidx_next = vidx_reg;
        vcnt_next = vcnt_reg;
        vage_next = vage_reg;
        ffound_next = ffound_reg;
        fidx_next = fidx_reg;
        rv_next = rv_reg;
        rdval_next = rdval_reg;
        out_valid_next = out_valid_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dcnt_next = dcnt_reg;
        valid_next = valid_reg;
        rd_addr = iss_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = hidx_reg;
        wr_data = hslot_reg;

        // Configuration writes
        if (cfg.valid)
        begin
            if (cfg.index == CFG_CAPACITY)
            begin
                cap_next = cfg.data[CAP_BITS-1:0];
            end
            else
            begin
                thr_next = cfg.data;
            end
        end

        // Drop the result beat when taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cmd_next = req.cmd;
                    key_next = KEY_BITS'(req.lookup_key);
                    val_next = DATA_BITS'(req.put_value);
                    iss_next = '0;
                    chk_next = '0;
                    hit_next = 1'b0;
                    vfound_next = 1'b0;
                    ffound_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Advance reads; check the slot read last cycle
                if (iss_reg < ENT_O)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (chk_reg != iss_reg)
                begin
                    chk_next = chk_reg + 1'b1;
                    if (valid_reg[chk_idx])
                    begin
                        if (!hit_reg && rd_data.key == key_reg)
                        begin
                            hit_next = 1'b1;
                            hidx_next = chk_idx;
                            hslot_next = rd_data;
                        end
                        if (!vfound_reg || rd_data.cnt < vcnt_reg
                            || (rd_data.cnt == vcnt_reg && cur_age > vage_reg))
                        begin
                            vfound_next = 1'b1;
                            vidx_next = chk_idx;
                            vcnt_next = rd_data.cnt;
                            vage_next = cur_age;
                        end
                    end
                    if (chk_reg + 1'b1 == ENT_O)
                    begin
                        state_next = S_DEC;
                    end
                end
            end
            S_DEC:
            begin
                rv_next = hit_reg;
                rdval_next = (hit_reg && cmd_reg == CMD_GET)
                    ? 32'(hslot_reg.data) : '0;
                if (hit_reg && (cmd_reg == CMD_GET || cap_eff != '0))
                begin
                    // Raise the hit entry
                    wr_en = 1'b1;
                    wr_addr = hidx_reg;
                    wr_data = hslot_reg;
                    if (cmd_reg == CMD_PUT)
                    begin
                        wr_data.data = val_reg;
                    end
                    if (hslot_reg.cnt != '1)
                    begin
                        wr_data.cnt = hslot_reg.cnt + 1'b1;
                    end
                    wr_data.stamp = stamp_reg;
                    stamp_next = stamp_reg + 1'b1;
                    state_next = S_WRITE;
                end
                else if (cmd_reg == CMD_PUT && !hit_reg && cap_eff != '0)
                begin
                    if (occ_reg >= OW'(cap_eff) && vfound_reg)
                    begin
                        valid_next[vidx_reg] = 1'b0;
                        if (occ_reg != '0)
                        begin
                            occ_next = occ_reg - 1'b1;
                        end
                        total_next = (total_reg > TOTAL_BITS'(vcnt_reg))
                            ? total_reg - TOTAL_BITS'(vcnt_reg) : '0;
                    end
                    state_next = S_EVRD;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_EVRD:
            begin
                // Find the first free slot
                ffound_next = 1'b0;
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!valid_reg[i])
                    begin
                        ffound_next = 1'b1;
                        fidx_next = IW'(i);
                    end
                end
                state_next = S_EVWT;
            end
            S_EVWT:
            begin
                if (ffound_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = fidx_reg;
                    wr_data.key = key_reg;
                    wr_data.data = val_reg;
                    wr_data.cnt = CNT_BITS'(1);
                    wr_data.stamp = stamp_reg;
                    stamp_next = stamp_reg + 1'b1;
                    valid_next[fidx_reg] = 1'b1;
                    occ_next = occ_reg + 1'b1;
                    state_next = S_WRITE;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_WRITE:
            begin
                // Count the access and start the divider
                if (total_reg != '1)
                begin
                    total_next = total_reg + 1'b1;
                end
                quo_next = (total_reg != '1) ? total_reg + 1'b1 : total_reg;
                rem_next = '0;
                dcnt_next = '0;
                if (occ_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle
                if (dcnt_reg == DCW'(DW))
                begin
                    if (quo_reg > DW'(thr_reg))
                    begin
                        iss_next = '0;
                        chk_next = '0;
                        state_next = S_AGERD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                    if (rem_shift >= (DW+1)'(occ_reg))
                    begin
                        rem_next = rem_shift - (DW+1)'(occ_reg);
                        quo_next = {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_shift;
                        quo_next = {quo_reg[DW-2:0], 1'b0};
                    end
                end
            end
            S_AGERD:
            begin
                rd_addr = chk_idx;
                state_next = S_AGEWT;
            end
            S_AGEWT:
            begin
                // Hold the read address so the slot data stays in place
                rd_addr = chk_idx;
                state_next = S_AGEWR;
            end
            S_AGEWR:
            begin
                // Age one slot, then move on
                if (valid_reg[chk_idx] && rd_data.cnt > CNT_BITS'(thr_reg))
                begin
                    wr_en = 1'b1;
                    wr_addr = chk_idx;
                    wr_data = rd_data;
                    wr_data.cnt = (rd_data.cnt > dec + 1'b1) ? rd_data.cnt - dec
                        : CNT_BITS'(1);
                    wr_data.stamp = stamp_reg;
                    stamp_next = stamp_reg + 1'b1;
                end
                chk_next = chk_reg + 1'b1;
                if (chk_reg + 1'b1 == ENT_O)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_AGERD;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg <= CAP_RESET;
            thr_reg <= THR_RESET;
            stamp_reg <= '0;
            total_reg <= '0;
            occ_reg <= '0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            iss_reg <= '0;
            chk_reg <= '0;
            dcnt_reg <= '0;
            hit_reg <= 1'b0;
            vfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg <= cap_next;
            thr_reg <= thr_next;
            stamp_reg <= stamp_next;
            total_reg <= total_next;
            occ_reg <= occ_next;
            valid_reg <= valid_next;
            out_valid_reg <= out_valid_next;
            iss_reg <= iss_next;
            chk_reg <= chk_next;
            dcnt_reg <= dcnt_next;
            hit_reg <= hit_next;
            vfound_reg <= vfound_next;
            ffound_reg <= ffound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        val_reg <= val_next;
        hidx_reg <= hidx_next;
        hslot_reg <= hslot_next;
        vidx_reg <= vidx_next;
        vcnt_reg <= vcnt_next;
        vage_reg <= vage_next;
        fidx_reg <= fidx_next;
        rv_reg <= rv_next;
        rdval_reg <= rdval_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

`include "lfu_cache_with_frequency_aging_assert.svh"
    `LFU_ASSERT(a_occ_range, occ_reg <= ENT_O, "occupancy beyond entry count")
    `LFU_ASSERT(a_occ_match, occ_reg == OW'($countones(valid_reg)), "occupancy mismatch")
    `LFU_ASSERT_NEXT(a_no_accept_busy, req.valid && req.ready, state_reg == S_SCAN, "bad start")
    `LFU_ASSERT(a_getmiss_zero, (rsp.valid && !rsp.hit) |-> rsp.read_value == '0, "miss value")
endmodule
